// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files that check themselves.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/tdf_pkg.sv -----
// Package for the trial-division factorizer: widths, field sizes, FSM states.
// No dependencies.
`default_nettype none
package tdf_pkg;

	localparam int VALUE_WIDTH = 31;
	localparam int EXP_W       = 5;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);
	localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((VALUE_WIDTH + EXP_W + 7) / 8) * 8;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [EXP_W-1:0]       exp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_EVAL,
		ST_PUSH,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		value_t prime;
		exp_t   exponent;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/tdf_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on tdf_pkg.
`default_nettype none
module tdf_div
	import tdf_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire value_t dividend,
	input  wire value_t divisor,
	output logic        done,
	output value_t      quot,
	output value_t      remain
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	value_t           dq_q;
	value_t           rem_q;

	logic [VALUE_WIDTH:0] trial;
	logic [VALUE_WIDTH:0] diff;
	logic                 ge;

	assign trial = {rem_q, dq_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = !diff[VALUE_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
			dq_q  <= {dq_q[VALUE_WIDTH-2:0], ge};
		end
	end

	assign done   = done_q;
	assign quot   = dq_q;
	assign remain = rem_q;

endmodule
`default_nettype wire

// ----- rtl/trial_division_factorizer.sv -----
// Trial-division factorizer top level: control FSM, result staging, stream ports.
// Depends on tdf_pkg, tdf_div and assert_macros.svh.
//
//   port group   dir  payload                                   done when
//   s_*          in   tdata[30:0] value                         tvalid & tready
//   m_*          out  tdata[30:0] prime, [35:31] exponent, tlast tvalid & tready
//
// Each trial division passes through ST_LOAD, ST_DIV and ST_EVAL; ST_DIV waits for the divider.
// A prime input needs about sqrt(value) / 2 trial divisions.
// Inputs 0 and 1 go from ST_IDLE straight to ST_FLUSH.
// One item is in work at a time; s_tready is high only while idle.
// A stalled m_tready holds the FSM once both the output and staging registers are full.
// arst_n clears the control state only.
`default_nettype none
`include "assert_macros.svh"
module trial_division_factorizer
	import tdf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // value
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // prime, exponent
	output logic                        m_tlast
);

	state_t  state_q, state_nxt;
	value_t  n_q, d_q;
	exp_t    e_q;
	logic    fin_q;
	logic    pend_v_q;
	result_t pend_q;
	logic    out_v_q;
	result_t out_q;
	logic    out_last_q;

	logic    div_done;
	value_t  quot, remain;
	value_t  value_in, d_next;
	result_t new_res;
	logic    in_xfer, out_free, divides, small_in;
	logic    div_start, do_divides, do_emit, do_stop, do_next, do_push, do_flush;

	assign value_in = s_tdata[VALUE_WIDTH-1:0];
	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_v_q || m_tready;
	assign small_in = value_in < VALUE_WIDTH'(2);
	assign divides  = (remain == '0) && ((e_q != '0) || (d_q <= quot));
	assign d_next   = (d_q == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3) : d_q + VALUE_WIDTH'(2);
	assign new_res.prime    = fin_q ? n_q : d_q;
	assign new_res.exponent = fin_q ? EXP_W'(1) : e_q;

	tdf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (d_q),
		.done     (div_done),
		.quot     (quot),
		.remain   (remain)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = small_in ? ST_FLUSH : ST_LOAD;
			ST_LOAD:  state_nxt = ST_DIV;
			ST_DIV:   if (div_done) state_nxt = ST_EVAL;
			ST_EVAL: begin
				if (divides) state_nxt = ST_LOAD;
				else if (e_q != '0) state_nxt = ST_PUSH;
				else if (d_q > quot) state_nxt = (n_q > VALUE_WIDTH'(1)) ? ST_PUSH : ST_FLUSH;
				else state_nxt = ST_LOAD;
			end
			ST_PUSH:  if (!pend_v_q || out_free) state_nxt = fin_q ? ST_FLUSH : ST_LOAD;
			ST_FLUSH: if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// control strobes
	always_comb begin
		s_tready   = 1'b0;
		div_start  = 1'b0;
		do_divides = 1'b0;
		do_emit    = 1'b0;
		do_stop    = 1'b0;
		do_next    = 1'b0;
		do_push    = 1'b0;
		do_flush   = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_LOAD:  div_start = 1'b1;
			ST_EVAL: begin
				if (divides) do_divides = 1'b1;
				else if (e_q != '0) do_emit = 1'b1;
				else if (d_q > quot) do_stop = 1'b1;
				else do_next = 1'b1;
			end
			ST_PUSH:  do_push = !pend_v_q || out_free;
			ST_FLUSH: do_flush = out_free;
			default:  s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			fin_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (m_tready) out_v_q <= 1'b0;
			if (in_xfer) begin
				fin_q    <= 1'b0;
				pend_v_q <= small_in;
			end
			if (do_emit) fin_q <= 1'b0;
			if (do_stop) fin_q <= 1'b1;
			if (do_push) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_v_q <= 1'b1;
			end
			if (do_flush) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			n_q    <= value_in;
			d_q    <= VALUE_WIDTH'(2);
			e_q    <= '0;
			pend_q <= '0;
		end
		if (do_divides) begin
			n_q <= quot;
			e_q <= e_q + EXP_W'(1);
		end
		if (do_next) d_q <= d_next;
		if (do_push) begin
			pend_q <= new_res;
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
			if (!fin_q) begin
				d_q <= d_next;
				e_q <= '0;
			end
		end
		if (do_flush) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = OUT_TDATA_W'({out_q.exponent, out_q.prime});

	`ASSERT_IMPL(a_done_in_div, div_done, state_q == ST_DIV)
	`ASSERT_IMPL(a_push_has_exp, state_q == ST_PUSH && !fin_q, e_q != '0)
	`ASSERT_NEXT(a_flush_drains, do_flush, out_v_q && m_tlast && !pend_v_q)

endmodule
`default_nettype wire

// ----- verif/tb_trial_division_factorizer.sv -----
// Testbench for trial_division_factorizer: streams integers in, predicts each
// prime/exponent result list in-bench and checks every output transfer in order.
// Depends on tdf_pkg and the trial_division_factorizer RTL.
module tb_trial_division_factorizer;
	import tdf_pkg::*;

	localparam int MAX_FACTORS    = 9;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int WATCHDOG_LIMIT = 4_000_000;
	localparam int DRAIN_CYCLES   = 100;

	typedef struct {
		value_t prime;
		exp_t   exponent;
		logic   last;
	} factor_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // value
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // prime, exponent
	logic                   m_tlast;

	factor_t expected_factors[$];
	int      mismatches      = 0;
	int      values_sent     = 0;
	int      factors_checked = 0;
	int      stall_cycles    = 0;
	bit      idle_off        = 1'b0;
	bit      rx_hold_pending = 1'b0;

	trial_division_factorizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// trial division: 2, then odd candidates while d*d <= remaining cofactor
	task automatic push_factorization(input value_t v);
		longint unsigned n;
		longint unsigned d;
		int              e;
		int              count;
		factor_t         found[MAX_FACTORS];
		n = v;
		d = 2;
		count = 0;
		if (n < 2) begin
			found[0] = '{prime: '0, exponent: '0, last: 1'b0};
			count = 1;
		end else begin
			while (count < MAX_FACTORS && d <= n / d) begin
				if (n % d == 0) begin
					e = 0;
					while (n % d == 0) begin
						n = n / d;
						e++;
					end
					found[count] = '{prime: value_t'(d), exponent: exp_t'(e), last: 1'b0};
					count++;
				end
				d = (d == 2) ? 3 : d + 2;
			end
			if (count < MAX_FACTORS && n > 1) begin
				found[count] = '{prime: value_t'(n), exponent: exp_t'(1), last: 1'b0};
				count++;
			end
		end
		found[count-1].last = 1'b1;
		for (int i = 0; i < count; i++)
			expected_factors.push_back(found[i]);
	endtask

	// called at a rising edge; returns at the edge where the transfer happened
	task automatic send_value(input value_t v);
		int gap;
		gap = idle_off ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push_factorization(v);
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'(v);
		do @(posedge clk); while (!s_tready);
		values_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_factors.size() != 0) @(posedge clk);
	endtask

	function automatic value_t random_value();
		longint unsigned n;
		longint unsigned f;
		int              kind;
		kind = $urandom_range(0, 9);
		if (kind == 0)
			return value_t'($urandom_range(0, 255));
		if (kind <= 2)
			return value_t'(longint'($urandom_range(1, 4095)) << $urandom_range(0, 19));
		n = 1;
		repeat ($urandom_range(1, 12)) begin
			f = $urandom_range(2, 127);
			if (n * f <= 64'h7FFF_FFFF)
				n = n * f;
		end
		return value_t'(n);
	endfunction

	task automatic test_trivial_inputs();
		send_value(value_t'(0));
		send_value(value_t'(1));
	endtask

	task automatic test_small_cases();
		// primes, squares of candidates and a prime cofactor left after division
		send_value(value_t'(2));
		send_value(value_t'(3));
		send_value(value_t'(4));
		send_value(value_t'(9));
		send_value(value_t'(25));
		send_value(value_t'(49));
		send_value(value_t'(97));
		send_value(value_t'(393222));
		send_value(value_t'(1000));
	endtask

	task automatic test_field_extremes();
		send_value(value_t'(32'h7FFF_FFFF));
		send_value(value_t'(32'h4000_0000));
		send_value(value_t'(32'h7FFF_FFFE));
		send_value(value_t'(1162261467));
		send_value(value_t'(223092870));
		send_value(value_t'(16777213));
		wait_drained();
	endtask

	task automatic test_random_values();
		repeat (64) send_value(random_value());
		wait_drained();
	endtask

	task automatic test_output_stall();
		@(posedge clk);
		rx_hold_pending = 1'b1;
		send_value(value_t'(223092870));
		repeat (3) begin
			send_value(value_t'(32'h7FFF_FFFE));
			send_value(value_t'(223092870));
		end
		send_value(random_value());
		wait_drained();
	endtask

	task automatic test_back_to_back();
		@(posedge clk);
		idle_off = 1'b1;
		send_value(value_t'(0));
		send_value(value_t'(1));
		repeat (10) send_value(random_value());
		wait_drained();
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		m_tready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_trivial_inputs();
		test_small_cases();
		test_field_extremes();
		test_random_values();
		test_output_stall();
		test_back_to_back();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Factored %0d values (0/1, prime and power edges, random smooth numbers,", values_sent);
		$display("output stall and gapless runs); %0d factor transfers checked.", factors_checked);
		if (mismatches == 0 && expected_factors.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// receiver: random holdoff per transfer, one long holdoff on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_pending) begin
				rx_hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
			end
			gap = idle_off ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		factor_t exp_f;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_factors.size() == 0) begin
				report_mismatch($sformatf("unexpected result prime=%0d exponent=%0d",
					m_tdata[VALUE_WIDTH-1:0], m_tdata[VALUE_WIDTH+EXP_W-1:VALUE_WIDTH]));
			end else begin
				exp_f = expected_factors.pop_front();
				factors_checked++;
				if (m_tdata[VALUE_WIDTH-1:0] !== exp_f.prime)
					report_mismatch($sformatf("prime got %0d want %0d",
						m_tdata[VALUE_WIDTH-1:0], exp_f.prime));
				if (m_tdata[VALUE_WIDTH+EXP_W-1:VALUE_WIDTH] !== exp_f.exponent)
					report_mismatch($sformatf("exponent got %0d want %0d for prime %0d",
						m_tdata[VALUE_WIDTH+EXP_W-1:VALUE_WIDTH], exp_f.exponent,
						exp_f.prime));
				if (m_tlast !== exp_f.last)
					report_mismatch($sformatf("tlast got %0b want %0b for prime %0d",
						m_tlast, exp_f.last, exp_f.prime));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tdf_pkg.sv
rtl/tdf_div.sv
rtl/trial_division_factorizer.sv
verif/tb_trial_division_factorizer.sv
